// ===== hdl/assert_macros.svh =====
// Assertion macros for the printable run extractor RTL.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define PRX_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("prx assertion failed");

// cond must never be true outside reset
`define PRX_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("prx forbidden condition seen");

`else

`define PRX_ASSERT(lbl, clk, rst, prop)
`define PRX_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== hdl/prx_pkg.sv =====
// Shared types, codes and helpers for the printable run extractor.
// No dependencies; every RTL module refers to it by scoped names.
package prx_pkg;

  // run buffer geometry
  localparam int unsigned MAX_KEEP = 63;
  localparam int unsigned CNT_W    = $clog2(MAX_KEEP + 1);
  localparam int unsigned ADDR_W   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  // command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  // field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OFFSET_W  = 32;
  localparam int unsigned MINLEN_W  = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 6;
  localparam int unsigned TDATA_W   = BYTE_W + OFFSET_W;

  // input op codes
  localparam logic [OP_W-1:0] OP_DATA    = 2'd0;
  localparam logic [OP_W-1:0] OP_EOF     = 2'd1;
  localparam logic [OP_W-1:0] OP_DISCARD = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ENABLE = 2'd1;

  localparam logic [MINLEN_W-1:0] MIN_LENGTH_RST = 6'd4;

  // characters
  localparam logic [BYTE_W-1:0] CH_NEWLINE  = 8'd10;
  localparam logic [BYTE_W-1:0] CH_FORMFEED = 8'd12;
  localparam logic [BYTE_W-1:0] CH_SPACE    = 8'd32;
  localparam logic [BYTE_W-1:0] CH_TILDE    = 8'd126;
  localparam logic [BYTE_W-1:0] CH_HIGH     = 8'd128;

  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    CMD_STORE   = 2'd0,
    CMD_FLUSH   = 2'd1,
    CMD_DISCARD = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [BYTE_W-1:0]     data_byte;
    logic [OFFSET_W-1:0]   byte_offset;
  } cmd_t;

  typedef struct packed {
    logic [MINLEN_W-1:0] min_length;
    logic                offset_enable;
  } cfg_t;

  // space through tilde, form feed, and 128
  function automatic logic is_clean(input logic [BYTE_W-1:0] b);
    logic ok;
    ok = (b == CH_FORMFEED) || (b == CH_HIGH) || ((b >= CH_SPACE) && (b <= CH_TILDE));
    return ok;
  endfunction

endpackage

// ===== hdl/printable_run_extractor_core.sv =====
// Printable run extractor, top level. Collects runs of clean bytes (space
// through tilde, form feed, 128) from a byte stream and reports each run that
// reaches min_length as its characters followed by a newline item marked
// tlast, all carrying the run's start offset when offset_enable is set. At
// most 63 characters of a run are kept. Input items are taken one per cycle,
// while the queue has room, into a 4-deep command queue. The back end retires
// a stored byte, a discard or an unreported terminator as it pops it; for a
// reported run of n stored characters it starts the buffer read, emits each
// character, then emits the newline, paced by the registered buffer read and
// the output register. tready drops only while the queue is full.
// Depends on prx_pkg, prx_front, prx_cmd_fifo, prx_back.
module printable_run_extractor_core (
  input  logic                             clk,
  input  logic                             rst,
  // input items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [prx_pkg::TDATA_W-1:0]      s_tdata,   // data_byte [7:0], byte_offset [39:8]
  input  logic [prx_pkg::OP_W-1:0]         s_tuser,   // op [1:0]
  // result items
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [prx_pkg::TDATA_W-1:0]      m_tdata,   // out_char [7:0], start_offset [39:8]
  output logic                             m_tuser,   // offset_valid
  output logic                             m_tlast,   // last
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [prx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prx_pkg::CFG_DAT_W-1:0]    cfg_data
);

  prx_pkg::cfg_t cfg;
  prx_pkg::cmd_t push_cmd;
  prx_pkg::cmd_t q_cmd;
  logic          push;
  logic          q_full;
  logic          q_empty;
  logic          pop;

  // the user must write registers only while the block is idle; not enforced here, so always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_length    <= prx_pkg::MIN_LENGTH_RST;
      cfg.offset_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        prx_pkg::REG_MIN_LENGTH: begin
          cfg.min_length <= cfg_data[prx_pkg::MINLEN_W-1:0];
        end
        prx_pkg::REG_OFFSET_ENABLE: begin
          cfg.offset_enable <= cfg_data[0];
        end
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // front: classify and enqueue
  prx_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouples input acceptance from run flushing
  prx_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (q_cmd),
    .empty    (q_empty)
  );

  // back: run buffer and flush sequencer
  prx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== hdl/prx_front.sv =====
// Front end: accepts input items and turns them into back-end commands.
// Depends on prx_pkg.
module prx_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [prx_pkg::TDATA_W-1:0]   s_tdata,   // data_byte, byte_offset
  input  logic [prx_pkg::OP_W-1:0]      s_tuser,   // op
  input  logic                          q_full,
  output logic                          push,
  output prx_pkg::cmd_t                 push_cmd
);

  logic [prx_pkg::BYTE_W-1:0] b;
  logic                       keep;

  assign b        = s_tdata[prx_pkg::BYTE_W-1:0];
  assign s_tready = !q_full;

  always_comb begin
    push_cmd.data_byte   = b;
    push_cmd.byte_offset = s_tdata[prx_pkg::TDATA_W-1:prx_pkg::BYTE_W];
    push_cmd.kind        = prx_pkg::CMD_FLUSH;
    keep                 = 1'b1;
    case (s_tuser)
      prx_pkg::OP_DATA: begin
        // newline and dirty bytes terminate the run
        if (b != prx_pkg::CH_NEWLINE && prx_pkg::is_clean(b)) begin
          push_cmd.kind = prx_pkg::CMD_STORE;
        end
      end
      prx_pkg::OP_EOF: begin
        push_cmd.kind = prx_pkg::CMD_FLUSH;
      end
      prx_pkg::OP_DISCARD: begin
        push_cmd.kind = prx_pkg::CMD_DISCARD;
      end
      default: begin
        keep = 1'b0;  // unused op, swallowed
      end
    endcase
    push = s_tvalid && s_tready && keep;
  end

endmodule

// ===== hdl/prx_cmd_fifo.sv =====
// Small register FIFO carrying commands from front to back.
// Depends on prx_pkg.
module prx_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  prx_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output prx_pkg::cmd_t pop_cmd,
  output logic          empty
);

  prx_pkg::cmd_t                 entries [prx_pkg::CMDQ_DEPTH];
  logic [prx_pkg::CMDQ_PTR_W-1:0] wr_ptr;
  logic [prx_pkg::CMDQ_PTR_W-1:0] rd_ptr;
  logic [prx_pkg::CMDQ_PTR_W:0]   fill;

  assign full    = (fill == (prx_pkg::CMDQ_PTR_W+1)'(prx_pkg::CMDQ_DEPTH));
  assign empty   = (fill == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hdl/prx_back.sv =====
// Back end: run buffer, flush sequencer and output register.
// Depends on prx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module prx_back (
  input  logic                          clk,
  input  logic                          rst,
  input  prx_pkg::cfg_t                 cfg,
  input  logic                          q_empty,
  input  prx_pkg::cmd_t                 q_cmd,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [prx_pkg::TDATA_W-1:0]   m_tdata,   // out_char, start_offset
  output logic                          m_tuser,   // offset_valid
  output logic                          m_tlast    // last
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EMIT = 3'b010,
    ST_NL   = 3'b100
  } state_t;

  state_t                        state;
  prx_pkg::count_t               count;
  logic [prx_pkg::OFFSET_W-1:0]  run_start;
  logic [prx_pkg::ADDR_W-1:0]    idx;
  logic [prx_pkg::OFFSET_W-1:0]  flush_so;
  logic                          flush_ov;
  logic [prx_pkg::BYTE_W-1:0]    mem [prx_pkg::MAX_KEEP];
  logic [prx_pkg::BYTE_W-1:0]    rd_data;
  logic [prx_pkg::BYTE_W-1:0]    out_char;
  logic [prx_pkg::OFFSET_W-1:0]  out_offset;

  logic                          out_free;
  logic                          reported;
  logic                          room;
  logic                          mem_we;
  logic                          rd_en;
  logic [prx_pkg::ADDR_W-1:0]    rd_addr;
  prx_pkg::count_t               idx_inc;
  logic                          more;
  logic                          load_char;
  logic                          load_nl;

  assign m_tdata = {out_offset, out_char};

  always_comb begin
    out_free  = !m_tvalid || m_tready;
    pop       = !q_empty && (state == ST_IDLE);
    reported  = 7'(count) >= 7'(cfg.min_length);
    room      = count < prx_pkg::CNT_W'(prx_pkg::MAX_KEEP);
    idx_inc   = prx_pkg::CNT_W'(idx) + 1'b1;
    more      = idx_inc < count;
    load_char = (state == ST_EMIT) && out_free;
    load_nl   = (state == ST_NL) && out_free;
    mem_we    = pop && (q_cmd.kind == prx_pkg::CMD_STORE) && room;
    rd_en     = 1'b0;
    rd_addr   = '0;
    if (pop && (q_cmd.kind == prx_pkg::CMD_FLUSH) && reported && (count != '0)) begin
      rd_en = 1'b1;  // prefetch first character
    end else if (load_char && more) begin
      rd_en   = 1'b1;
      rd_addr = idx_inc[prx_pkg::ADDR_W-1:0];
    end
  end

  // run buffer, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[prx_pkg::ADDR_W-1:0]] <= q_cmd.data_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      run_start <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (load_char || load_nl) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            case (q_cmd.kind)
              prx_pkg::CMD_STORE: begin
                if (count == '0) begin
                  run_start <= q_cmd.byte_offset;
                end
                if (room) begin
                  count <= count + 1'b1;
                end
              end
              prx_pkg::CMD_FLUSH: begin
                if (!reported) begin
                  count <= '0;
                end else if (count == '0) begin
                  state <= ST_NL;
                end else begin
                  state <= ST_EMIT;
                end
              end
              default: begin
                count <= '0;
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (load_char && !more) begin
            state <= ST_NL;
          end
        end
        ST_NL: begin
          if (load_nl) begin
            count <= '0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop && (q_cmd.kind == prx_pkg::CMD_FLUSH)) begin
      idx      <= '0;
      flush_ov <= cfg.offset_enable;
      if (!cfg.offset_enable) begin
        flush_so <= '0;
      end else if (count == '0) begin
        flush_so <= q_cmd.byte_offset;  // empty run takes the terminator offset
      end else begin
        flush_so <= run_start;
      end
    end else if (load_char && more) begin
      idx <= idx_inc[prx_pkg::ADDR_W-1:0];
    end
    if (load_char) begin
      out_char   <= rd_data;
      out_offset <= flush_so;
      m_tuser    <= flush_ov;
      m_tlast    <= 1'b0;
    end else if (load_nl) begin
      out_char   <= prx_pkg::CH_NEWLINE;
      out_offset <= flush_so;
      m_tuser    <= flush_ov;
      m_tlast    <= 1'b1;
    end
  end

  `PRX_NEVER(a_count_bound, clk, rst, count > prx_pkg::CNT_W'(prx_pkg::MAX_KEEP))
  `PRX_ASSERT(a_emit_in_range, clk, rst,
    (state == ST_EMIT) |-> (count != '0) && (prx_pkg::CNT_W'(idx) < count))
  `PRX_ASSERT(a_nl_clears, clk, rst, load_nl |=> (count == '0) && (state == ST_IDLE))
  `PRX_NEVER(a_pop_busy, clk, rst, pop && (state != ST_IDLE))

endmodule
